// ----- hw/rtl/i2cms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitSelW  = 3;

  // Command codes carried on the mode field
  localparam logic [ModeW-1:0] MODE_TICK  = 3'd0;
  localparam logic [ModeW-1:0] MODE_START = 3'd1;
  localparam logic [ModeW-1:0] MODE_STOP  = 3'd2;
  localparam logic [ModeW-1:0] MODE_WRITE = 3'd3;
  localparam logic [ModeW-1:0] MODE_READ  = 3'd4;
  localparam logic [ModeW-1:0] MODE_SACK  = 3'd5;
  localparam logic [ModeW-1:0] MODE_RACK  = 3'd6;
  // Spare code: no command, handled as a plain tick
  localparam logic [ModeW-1:0] MODE_SPARE = 3'd7;

  localparam logic [TicksW-1:0] STEP_TICKS_RST = 16'd10;
  localparam logic [ByteW-1:0]  RX_MSB         = 8'h80;

  // Register map
  localparam logic [2:0] ADDR_STEP_TICKS = 3'd0;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             busy_res;
    logic             done_res;
    logic             rejected;
    logic [ByteW-1:0] rx_byte;
    logic             ack_received;
  } res_t;

  function automatic logic [IdxW-1:0] cmd_len(input logic [ModeW-1:0] mode);
    logic [IdxW-1:0] len;
    unique case (mode)
      MODE_START: len = 5'd4;
      MODE_STOP:  len = 5'd3;
      MODE_WRITE: len = 5'd24;
      MODE_READ:  len = 5'd24;
      MODE_SACK:  len = 5'd3;
      MODE_RACK:  len = 5'd4;
      default:    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/i2cms_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2cms_seq import i2cms_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [TicksW-1:0] step_ticks_i,
  input  wire logic              accept_i,
  input  wire logic [ModeW-1:0]  mode_i,
  input  wire logic [ByteW-1:0]  data_byte_i,
  input  wire logic              ack_value_i,
  input  wire logic              sda_line_i,
  output res_t                   res_o
);

  logic [ModeW-1:0]  cmd_q, cmd_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [TicksW-1:0] wait_q, wait_d;
  logic [ByteW-1:0]  tx_q, tx_d;
  logic [ByteW-1:0]  rx_q, rx_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              ack_q, ack_d;

  logic              is_cmd;
  logic              busy;
  logic              start;
  logic              gap_over;
  logic              finish;
  logic              run;
  logic              rej;
  logic [ModeW-1:0]  cmd_eff;
  logic [IdxW-1:0]   idx_eff;
  logic [ByteW-1:0]  tx_eff;
  logic [ByteW-1:0]  rx_eff;
  logic [TicksW-1:0] gap;
  logic [8:0]        idx_x11;
  logic [BitSelW-1:0] bit_sel;
  logic [IdxW-1:0]   phase;

  assign is_cmd   = (mode_i != MODE_TICK) && (mode_i != MODE_SPARE);
  assign busy     = (cmd_q != MODE_TICK);
  assign start    = !busy && is_cmd;
  assign rej      = busy && is_cmd;
  assign gap_over = (wait_q <= 16'd1);
  assign finish   = busy && gap_over && (idx_q >= cmd_len(cmd_q));
  assign run      = start || (busy && gap_over && (idx_q < cmd_len(cmd_q)));
  assign gap      = (step_ticks_i == '0) ? 16'd1 : step_ticks_i;

  assign cmd_eff = start ? mode_i : cmd_q;
  assign idx_eff = start ? '0 : idx_q;
  assign tx_eff  = !start ? tx_q :
                   (mode_i == MODE_SACK) ? (ack_value_i ? RX_MSB : '0) : data_byte_i;
  assign rx_eff  = (start && (mode_i == MODE_READ)) ? '0 : rx_q;

  // idx / 3 for idx below 32: multiply by 11, drop five bits
  assign idx_x11 = 9'(idx_eff) * 9'd11;
  assign bit_sel = idx_x11[7:5];
  assign phase   = idx_eff - 5'(idx_x11[7:5]) * 5'd3;

  always_comb begin
    cmd_d  = cmd_eff;
    idx_d  = idx_eff;
    wait_d = wait_q;
    tx_d   = tx_eff;
    rx_d   = rx_eff;
    scl_d  = scl_q;
    sda_d  = sda_q;
    ack_d  = ack_q;
    if (busy && !gap_over) begin
      wait_d = wait_q - 16'd1;
    end
    if (finish) begin
      cmd_d  = MODE_TICK;
      idx_d  = '0;
      wait_d = '0;
    end
    if (run) begin
      idx_d  = idx_eff + 5'd1;
      wait_d = gap;
      unique case (cmd_eff)
        MODE_START: begin
          if (idx_eff == 5'd0) sda_d = 1'b1;
          else if (idx_eff == 5'd1) scl_d = 1'b1;
          else if (idx_eff == 5'd2) sda_d = 1'b0;
          else scl_d = 1'b0;
        end
        MODE_STOP: begin
          if (idx_eff == 5'd0) sda_d = 1'b0;
          else if (idx_eff == 5'd1) scl_d = 1'b1;
          else sda_d = 1'b1;
        end
        MODE_WRITE: begin
          if (phase == 5'd0) sda_d = tx_eff[~bit_sel];
          else if (phase == 5'd1) scl_d = 1'b1;
          else scl_d = 1'b0;
        end
        MODE_READ: begin
          if (phase == 5'd0) scl_d = 1'b1;
          else if (phase == 5'd1) begin
            if (sda_line_i) rx_d = rx_eff | (RX_MSB >> bit_sel);
          end else scl_d = 1'b0;
        end
        MODE_SACK: begin
          if (idx_eff == 5'd0) sda_d = tx_eff[ByteW-1];
          else if (idx_eff == 5'd1) scl_d = 1'b1;
          else scl_d = 1'b0;
        end
        MODE_RACK: begin
          if (idx_eff == 5'd0) sda_d = 1'b1;
          else if (idx_eff == 5'd1) scl_d = 1'b1;
          else if (idx_eff == 5'd2) ack_d = sda_line_i;
          else scl_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= MODE_TICK;
      idx_q  <= '0;
      wait_q <= '0;
      tx_q   <= '0;
      rx_q   <= '0;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
      ack_q  <= 1'b0;
    end else if (accept_i) begin
      cmd_q  <= cmd_d;
      idx_q  <= idx_d;
      wait_q <= wait_d;
      tx_q   <= tx_d;
      rx_q   <= rx_d;
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      ack_q  <= ack_d;
    end
  end

  always_comb begin
    res_o.scl_level    = scl_d;
    res_o.sda_level    = sda_d;
    res_o.busy_res     = (cmd_d != MODE_TICK);
    res_o.done_res     = finish;
    res_o.rejected     = rej;
    res_o.rx_byte      = rx_d;
    res_o.ack_received = ack_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/i2cms_skid.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2cms_skid import i2cms_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic stall_i,
  output res_t      data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = out_valid_q && !stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // drain the skid stage into the output register
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/i2c_master_bit_sequencer.sv -----
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  mode, data_byte, ack_value, sda_line
// out      output     out_valid_o/out_stall_i scl/sda level, busy, done, rejected,
//                                            rx_byte, ack_received
// cfg      input      psel/penable/pwrite    step_ticks at address 0
//
// One request per cycle unless in_stall_o is high; results are registered.
// The pin sequencer state updates in the same cycle the request is taken.
// A two-entry output buffer lets one more request in while a result waits;
// in_stall_o rises only when both entries hold results.
// Reset releases both lines, clears all state and sets step_ticks to 10.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer import i2cms_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ModeW-1:0]  mode_i,
  input  wire logic [ByteW-1:0]  data_byte_i,
  input  wire logic              ack_value_i,
  input  wire logic              sda_line_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   scl_level_o,
  output logic                   sda_level_o,
  output logic                   busy_res_o,
  output logic                   done_res_o,
  output logic                   rejected_o,
  output logic [ByteW-1:0]       rx_byte_o,
  output logic                   ack_received_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [TicksW-1:0] step_ticks_q;
  logic              cfg_wr;
  logic              full;
  logic              accept;
  res_t              res;
  res_t              res_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_STEP_TICKS);
  assign prdata = (paddr == ADDR_STEP_TICKS) ? {16'd0, step_ticks_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ticks_q <= STEP_TICKS_RST;
    end else if (cfg_wr) begin
      step_ticks_q <= pwdata[TicksW-1:0];
    end
  end

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  i2cms_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_ticks_i (step_ticks_q),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .ack_value_i  (ack_value_i),
    .sda_line_i   (sda_line_i),
    .res_o        (res)
  );

  i2cms_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign scl_level_o    = res_out.scl_level;
  assign sda_level_o    = res_out.sda_level;
  assign busy_res_o     = res_out.busy_res;
  assign done_res_o     = res_out.done_res;
  assign rejected_o     = res_out.rejected;
  assign rx_byte_o      = res_out.rx_byte;
  assign ack_received_o = res_out.ack_received;

endmodule

`default_nettype wire

// ----- hw/rtl/i2cms_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2cms_checker import i2cms_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic             scl_level_o,
  input wire logic             sda_level_o,
  input wire logic             busy_res_o,
  input wire logic             done_res_o,
  input wire logic [ByteW-1:0] rx_byte_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rx_byte_o)
      && $stable(scl_level_o) && $stable(sda_level_o))
    else $error("stalled result changed");

  // completion tick leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done while still busy");

  // input stalls only with a result already waiting
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // buffer fills only after a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_stall_i) && $past(in_valid_i))
    else $error("input stall without output backpressure");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .scl_level_o (scl_level_o),
  .sda_level_o (sda_level_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .rx_byte_o   (rx_byte_o)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import i2cms_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ModeW-1:0]  mode_i = MODE_TICK;
  logic [ByteW-1:0]  data_byte_i = '0;
  logic              ack_value_i = 1'b0;
  logic              sda_line_i = 1'b1;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              scl_level_o;
  logic              sda_level_o;
  logic              busy_res_o;
  logic              done_res_o;
  logic              rejected_o;
  logic [ByteW-1:0]  rx_byte_o;
  logic              ack_received_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Sequencer mirror, updated as each request is taken
  logic [TicksW-1:0] step_ticks_q = STEP_TICKS_RST;
  logic [ModeW-1:0]  seq_cmd = MODE_TICK;
  logic [IdxW-1:0]   seq_idx = '0;
  logic [TicksW-1:0] seq_wait = '0;
  logic [ByteW-1:0]  seq_tx = '0;
  logic [ByteW-1:0]  seq_rx = '0;
  logic              seq_scl = 1'b1;
  logic              seq_sda = 1'b1;
  logic              seq_ack = 1'b0;

  res_t bus_state_q[$];
  int   n_err = 0;
  bit   steady = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;

  i2c_master_bit_sequencer u_dut (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void drive_pins(input logic [ModeW-1:0] cmd, input logic [IdxW-1:0] idx,
                                     input logic sda_in);
    logic [2:0] bsel;
    logic [1:0] ph;
    bsel = 3'(idx / 5'd3);
    ph   = 2'(idx % 5'd3);
    case (cmd)
      MODE_START: begin
        if (idx == 0) seq_sda = 1'b1;
        else if (idx == 1) seq_scl = 1'b1;
        else if (idx == 2) seq_sda = 1'b0;
        else seq_scl = 1'b0;
      end
      MODE_STOP: begin
        if (idx == 0) seq_sda = 1'b0;
        else if (idx == 1) seq_scl = 1'b1;
        else seq_sda = 1'b1;
      end
      MODE_WRITE: begin
        if (ph == 0) seq_sda = seq_tx[3'd7 - bsel];
        else if (ph == 1) seq_scl = 1'b1;
        else seq_scl = 1'b0;
      end
      MODE_READ: begin
        if (ph == 0) seq_scl = 1'b1;
        else if (ph == 1) begin
          if (sda_in) seq_rx[3'd7 - bsel] = 1'b1;
        end else seq_scl = 1'b0;
      end
      MODE_SACK: begin
        if (idx == 0) seq_sda = seq_tx[7];
        else if (idx == 1) seq_scl = 1'b1;
        else seq_scl = 1'b0;
      end
      MODE_RACK: begin
        if (idx == 0) seq_sda = 1'b1;
        else if (idx == 1) seq_scl = 1'b1;
        else if (idx == 2) seq_ack = sda_in;
        else seq_scl = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Offer one tick request, wait for it to be taken, then advance the mirror
  task automatic send_tick(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] data,
                           input logic ackv, input logic sda);
    logic              is_cmd;
    logic              rej;
    logic              done;
    logic [IdxW-1:0]   len;
    logic [TicksW-1:0] gap;
    res_t              r;
    while (!steady && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    data_byte_i <= data;
    ack_value_i <= ackv;
    sda_line_i  <= sda;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    is_cmd = (mode >= MODE_START) && (mode <= MODE_RACK);
    gap    = (step_ticks_q == '0) ? TicksW'(1) : step_ticks_q;
    rej    = 1'b0;
    done   = 1'b0;
    case (seq_cmd)
      MODE_START, MODE_RACK: len = 5'd4;
      MODE_STOP, MODE_SACK:  len = 5'd3;
      MODE_WRITE, MODE_READ: len = 5'd24;
      default:               len = 5'd0;
    endcase
    if (seq_cmd == MODE_TICK) begin
      if (is_cmd) begin
        seq_cmd = mode;
        seq_idx = '0;
        seq_tx  = (mode == MODE_SACK) ? {ackv, 7'd0} : data;
        if (mode == MODE_READ) seq_rx = '0;
        drive_pins(seq_cmd, seq_idx, sda);
        seq_idx++;
        seq_wait = gap;
      end
    end else begin
      rej = is_cmd;
      if (seq_wait > 1) begin
        seq_wait--;
      end else if (seq_idx >= len) begin
        seq_cmd  = MODE_TICK;
        seq_idx  = '0;
        seq_wait = '0;
        done     = 1'b1;
      end else begin
        drive_pins(seq_cmd, seq_idx, sda);
        seq_idx++;
        seq_wait = gap;
      end
    end

    r.scl_level    = seq_scl;
    r.sda_level    = seq_sda;
    r.busy_res     = (seq_cmd != MODE_TICK);
    r.done_res     = done;
    r.rejected     = rej;
    r.rx_byte      = seq_rx;
    r.ack_received = seq_ack;
    bus_state_q.push_back(r);
  endtask

  // Mostly start a command when idle; while busy mostly tick, now and then a stray command
  task automatic send_rand();
    logic [ModeW-1:0] m;
    int p;
    p = $urandom_range(99);
    if (seq_cmd == MODE_TICK) begin
      if (p < 75) m = ModeW'($urandom_range(MODE_START, MODE_RACK));
      else m = (p < 90) ? MODE_TICK : MODE_SPARE;
    end else begin
      if (p < 12) m = ModeW'($urandom_range(MODE_START, MODE_RACK));
      else m = (p < 20) ? MODE_SPARE : MODE_TICK;
    end
    send_tick(m, ByteW'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic run_to_idle();
    while (seq_cmd != MODE_TICK) send_rand();
  endtask

  task automatic run_cmd(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] data,
                         input logic ackv);
    send_tick(mode, data, ackv, 1'($urandom));
    run_to_idle();
  endtask

  // Drop valid and hold until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (bus_state_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_step_ticks(input logic [TicksW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_STEP_TICKS;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    step_ticks_q = val;
  endtask

  task automatic test_reset_ticks();
    run_cmd(MODE_START, 8'h00, 1'b0);
    run_cmd(MODE_STOP, 8'hFF, 1'b1);
    settle();
  endtask

  // Zero step count behaves as one tick between operations
  task automatic test_all_commands();
    write_step_ticks('0);
    run_cmd(MODE_START, 8'h5A, 1'b0);
    run_cmd(MODE_WRITE, 8'hFF, 1'b0);
    run_cmd(MODE_RACK, 8'h00, 1'b1);
    run_cmd(MODE_WRITE, 8'h00, 1'b1);
    run_cmd(MODE_WRITE, 8'hA5, 1'b0);
    send_tick(MODE_READ, 8'h00, 1'b0, 1'b1);
    while (seq_cmd != MODE_TICK) send_tick(MODE_TICK, 8'hFF, 1'b1, 1'b1);
    send_tick(MODE_READ, 8'hFF, 1'b1, 1'b0);
    while (seq_cmd != MODE_TICK) send_tick(MODE_TICK, 8'h00, 1'b0, 1'b0);
    run_cmd(MODE_READ, 8'h3C, 1'b0);
    run_cmd(MODE_SACK, 8'hFF, 1'b0);
    run_cmd(MODE_SACK, 8'h00, 1'b1);
    run_cmd(MODE_RACK, 8'hFF, 1'b0);
    run_cmd(MODE_STOP, 8'h00, 1'b0);
    send_tick(MODE_SPARE, 8'hFF, 1'b1, 1'b0);
    settle();
  endtask

  task automatic test_rejects();
    write_step_ticks(16'd2);
    send_tick(MODE_START, 8'h00, 1'b0, 1'b1);
    send_tick(MODE_WRITE, 8'hC3, 1'b1, 1'b0);
    send_tick(MODE_SPARE, 8'h00, 1'b0, 1'b1);
    send_tick(MODE_STOP, 8'h00, 1'b0, 1'b0);
    // Stop right before the completion tick, then land a command on it
    while (seq_idx < 5'd4 || seq_wait > 1) send_tick(MODE_TICK, 8'h00, 1'b0, 1'($urandom));
    send_tick(MODE_WRITE, 8'h81, 1'b0, 1'b1);
    send_tick(MODE_SPARE, 8'h18, 1'b1, 1'b0);
    run_cmd(MODE_RACK, 8'h00, 1'b0);
    settle();
  endtask

  task automatic test_random();
    logic [TicksW-1:0] ticks[4];
    ticks[0] = 16'd1;
    ticks[1] = 16'd3;
    ticks[2] = TicksW'($urandom_range(2, 6));
    ticks[3] = 16'd2;
    for (int ph = 0; ph < 4; ph++) begin
      write_step_ticks(ticks[ph]);
      for (int i = 0; i < 350; i++) begin
        steady = (ph == 1) && (i >= 100) && (i < 300);
        send_rand();
      end
      steady = 1'b0;
      run_to_idle();
      settle();
    end
  endtask

  // Keep offering requests while the output side holds off
  task automatic test_backpressure();
    write_step_ticks(16'd1);
    hold_req = 1'b1;
    repeat (40) send_rand();
    run_to_idle();
    settle();
  endtask

  task automatic test_max_step();
    write_step_ticks(16'hFFFF);
    send_tick(MODE_START, 8'h00, 1'b0, 1'b0);
    repeat (30) send_rand();
    settle();
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 31);
    end
  end

  function automatic void chk_field(input string name, input logic [7:0] e, input logic [7:0] a);
    if (a !== e) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      n_err++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_state_q.size() == 0) begin
        $error("result with no request outstanding");
        n_err++;
      end else begin
        e = bus_state_q.pop_front();
        chk_field("scl_level", e.scl_level, scl_level_o);
        chk_field("sda_level", e.sda_level, sda_level_o);
        chk_field("busy_res", e.busy_res, busy_res_o);
        chk_field("done_res", e.done_res, done_res_o);
        chk_field("rejected", e.rejected, rejected_o);
        chk_field("rx_byte", e.rx_byte, rx_byte_o);
        chk_field("ack_received", e.ack_received, ack_received_o);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_ticks();
    test_all_commands();
    test_rejects();
    test_random();
    test_backpressure();
    test_max_step();
    repeat (5) @(posedge clk_i);
    if (n_err == 0 && bus_state_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
